// File: rtl/scp_pkg.sv
`default_nettype none
package scp_pkg;

    localparam int DEFAULT_SECTIONS = 8;

    localparam int KIND_W  = 3;
    localparam int TIME_W  = 32;
    localparam int INDEX_W = 3;
    localparam int USED_W  = 4;

    localparam logic [KIND_W-1:0] KIND_INIT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] cycle_time;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0] min_val;
        logic [TIME_W-1:0] max_val;
        logic [TIME_W-1:0] sum_val;
    } t_rec;

    typedef struct packed {
        logic we;
        logic clr;
    } t_store_ctl;

    typedef struct packed {
        logic vld;
        t_rec rec;
    } t_ahead;

    function automatic t_rec fold_rec(input t_rec rec, input logic [TIME_W-1:0] elapsed);
        t_rec res;
        res.sum_val = rec.sum_val + elapsed;
        res.min_val = (rec.min_val == '0 || elapsed < rec.min_val) ? elapsed : rec.min_val;
        res.max_val = (elapsed > rec.max_val) ? elapsed : rec.max_val;
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/scp_if.sv
`default_nettype none
interface scp_in_if;
    import scp_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] cycle_time;

    modport source (output valid, output kind, output cycle_time, input ready);
    modport sink (input valid, input kind, input cycle_time, output ready);
endinterface

interface scp_out_if;
    import scp_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] section_index;
    logic [TIME_W-1:0]  elapsed_cycles;
    logic [TIME_W-1:0]  section_min;
    logic [TIME_W-1:0]  section_max;
    logic [TIME_W-1:0]  section_sum;
    logic [TIME_W-1:0]  start_total;
    logic [USED_W-1:0]  sections_used;

    modport source (output valid, output section_index, output elapsed_cycles,
                    output section_min, output section_max, output section_sum,
                    output start_total, output sections_used, input ready);
    modport sink (input valid, input section_index, input elapsed_cycles,
                  input section_min, input section_max, input section_sum,
                  input start_total, input sections_used, output ready);
endinterface
`default_nettype wire

// File: rtl/scp_input_stage.sv
`default_nettype none
module scp_input_stage
    import scp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_load,
    input  wire   i_adv,
    input  t_item i_item,
    output logic  o_vld,
    output t_item o_item
);

    logic  r_vld;
    t_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule
`default_nettype wire

// File: rtl/scp_record_store.sv
`default_nettype none
module scp_record_store
    import scp_pkg::*;
#(
    parameter int SECTIONS = DEFAULT_SECTIONS,
    parameter int IDX_W    = 3
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_store_ctl       i_ctl,
    input  wire [IDX_W-1:0]  i_wr_addr,
    input  t_rec             i_wr_rec,
    input  wire [IDX_W-1:0]  i_rd_addr,
    output t_ahead           o_ahead
);

    t_rec                r_mem [SECTIONS];
    logic [SECTIONS-1:0] r_vld;
    logic [SECTIONS-1:0] n_vld;
    t_rec                r_rd;
    logic                r_rd_vld;

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clr) begin
            n_vld = '0;
        end else if (i_ctl.we) begin
            n_vld[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_rd_vld <= n_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_wr_addr] <= i_wr_rec;
        end
        if (i_ctl.we && i_wr_addr == i_rd_addr) begin
            r_rd <= i_wr_rec;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_ahead.vld = r_rd_vld;
    assign o_ahead.rec = r_rd;

endmodule
`default_nettype wire

// File: rtl/section_cycle_profiler_unit.sv
`default_nettype none
// Section cycle profiler. Each request (kind, cycle_time) yields exactly one
// response: the request is registered in the input stage and then, while the
// response side keeps up, in the output register; a new request is taken every
// cycle under that condition. The current section's record lives in registers,
// the others in a SECTIONS-deep memory whose registered read holds the section
// after the current one (the current one when it is the last), so a next request
// finds its new record without waiting. Init and clear empty every record at once.
module section_cycle_profiler_unit
    import scp_pkg::*;
#(
    parameter int SECTIONS = DEFAULT_SECTIONS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    scp_in_if.sink     i_req,
    scp_out_if.source  o_rsp
);

    localparam int IDX_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int UCNT_W = $clog2(SECTIONS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SECTIONS - 1);

    t_item               w_in_item;
    t_item               w_item;
    logic                w_s1_vld;
    logic                w_adv;
    logic                w_proc;
    t_ahead              w_ahead;
    t_store_ctl          w_ctl;
    t_rec                w_upd;
    logic [TIME_W-1:0]   w_elapsed;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [IDX_W+2:0]    w_idx_pad;
    logic [UCNT_W+3:0]   w_used_pad;

    logic [IDX_W-1:0]    r_cur, n_cur;
    logic [UCNT_W-1:0]   r_used, n_used;
    logic [TIME_W-1:0]   r_start, n_start;
    logic [TIME_W-1:0]   r_mark, n_mark;
    t_rec                r_cur_rec, n_cur_rec;
    t_rec                r_s0_rec, n_s0_rec;
    logic [TIME_W-1:0]   n_elapsed;

    logic                r_out_vld;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [TIME_W-1:0]   r_out_elapsed;
    t_rec                r_out_rec;
    logic [TIME_W-1:0]   r_out_start;
    logic [USED_W-1:0]   r_out_used;

    assign w_adv  = !r_out_vld || o_rsp.ready;
    assign w_proc = w_s1_vld && w_adv;
    assign i_req.ready = !w_s1_vld || w_adv;

    assign w_in_item.kind       = i_req.kind;
    assign w_in_item.cycle_time = i_req.cycle_time;

    scp_input_stage u_input_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_req.valid && i_req.ready),
        .i_adv   (w_adv),
        .i_item  (w_in_item),
        .o_vld   (w_s1_vld),
        .o_item  (w_item)
    );

    assign w_elapsed = w_item.cycle_time - r_mark;
    assign w_upd     = fold_rec(r_cur_rec, w_elapsed);

    always_comb begin
        n_cur     = r_cur;
        n_used    = r_used;
        n_start   = r_start;
        n_mark    = r_mark;
        n_cur_rec = r_cur_rec;
        n_s0_rec  = r_s0_rec;
        n_elapsed = '0;
        w_ctl     = '0;
        if (w_proc) begin
            case (w_item.kind)
                KIND_INIT, KIND_CLEAR: begin
                    if (w_item.kind == KIND_INIT) begin
                        n_used = '0;
                    end
                    n_cur     = '0;
                    n_start   = '0;
                    n_mark    = '0;
                    n_cur_rec = '0;
                    n_s0_rec  = '0;
                    w_ctl.clr = 1'b1;
                end
                KIND_START: begin
                    n_start   = r_start + 1'b1;
                    n_cur     = '0;
                    n_cur_rec = r_s0_rec;
                    n_mark    = w_item.cycle_time;
                    if (r_used == '0) begin
                        n_used = UCNT_W'(1);
                    end
                end
                KIND_NEXT, KIND_STOP: begin
                    n_elapsed = w_elapsed;
                    w_ctl.we  = 1'b1;
                    n_cur_rec = w_upd;
                    if (r_cur == '0) begin
                        n_s0_rec = w_upd;
                    end
                    if (w_item.kind == KIND_NEXT) begin
                        n_mark = w_item.cycle_time;
                        if (r_cur < LAST) begin
                            n_cur     = r_cur + 1'b1;
                            n_cur_rec = w_ahead.vld ? w_ahead.rec : '0;
                        end
                        if (r_used < UCNT_W'(n_cur) + UCNT_W'(1)) begin
                            n_used = r_used + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_rd_addr = (n_cur < LAST) ? n_cur + 1'b1 : n_cur;

    scp_record_store #(
        .SECTIONS (SECTIONS),
        .IDX_W    (IDX_W)
    ) u_record_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_wr_addr (r_cur),
        .i_wr_rec  (w_upd),
        .i_rd_addr (w_rd_addr),
        .o_ahead   (w_ahead)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_used    <= '0;
            r_start   <= '0;
            r_mark    <= '0;
            r_cur_rec <= '0;
            r_s0_rec  <= '0;
        end else begin
            r_cur     <= n_cur;
            r_used    <= n_used;
            r_start   <= n_start;
            r_mark    <= n_mark;
            r_cur_rec <= n_cur_rec;
            r_s0_rec  <= n_s0_rec;
        end
    end

    assign w_idx_pad  = {3'b000, n_cur};
    assign w_used_pad = {4'b0000, n_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_idx     <= w_idx_pad[INDEX_W-1:0];
            r_out_elapsed <= n_elapsed;
            r_out_rec     <= n_cur_rec;
            r_out_start   <= n_start;
            r_out_used    <= w_used_pad[USED_W-1:0];
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.section_index  = r_out_idx;
    assign o_rsp.elapsed_cycles = r_out_elapsed;
    assign o_rsp.section_min    = r_out_rec.min_val;
    assign o_rsp.section_max    = r_out_rec.max_val;
    assign o_rsp.section_sum    = r_out_rec.sum_val;
    assign o_rsp.start_total    = r_out_start;
    assign o_rsp.sections_used  = r_out_used;

    a_init_drops_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_item.kind == KIND_INIT |=> r_used == '0 && r_cur == '0)
        else $error("init did not empty the profile");

    a_start_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && w_item.kind == KIND_START |=>
            r_cur == '0 && r_start == $past(r_start) + 1'b1)
        else $error("start did not rewind and count");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= LAST)
        else $error("current section beyond last");

    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UCNT_W'(SECTIONS))
        else $error("section count beyond depth");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> $stable(r_cur) && $stable(r_mark) && $stable(r_start))
        else $error("state moved without a request");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scp_pkg::*;

    localparam int PHASE_ITEMS = 445;

    typedef struct {
        logic [INDEX_W-1:0] section_index;
        logic [TIME_W-1:0]  elapsed_cycles;
        logic [TIME_W-1:0]  section_min;
        logic [TIME_W-1:0]  section_max;
        logic [TIME_W-1:0]  section_sum;
        logic [TIME_W-1:0]  start_total;
        logic [USED_W-1:0]  sections_used;
    } t_profile_report;

    logic clk;
    logic rst_n;

    scp_in_if  req_if ();
    scp_out_if rsp_if ();

    section_cycle_profiler_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic [TIME_W-1:0] prof_min [DEFAULT_SECTIONS];
    logic [TIME_W-1:0] prof_max [DEFAULT_SECTIONS];
    logic [TIME_W-1:0] prof_sum [DEFAULT_SECTIONS];
    logic [TIME_W-1:0] start_count;
    logic [TIME_W-1:0] mark_time;
    int                cur_section;
    int                used_sections;

    t_profile_report   expected_reports [$];
    int                fail_count;
    int                items_sent;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic [TIME_W-1:0] clock_now;

    always #2 clk = ~clk;

    function automatic void clear_profile();
        for (int i = 0; i < DEFAULT_SECTIONS; i++) begin
            prof_min[i] = '0;
            prof_max[i] = '0;
            prof_sum[i] = '0;
        end
        start_count = '0;
        cur_section = 0;
        mark_time   = '0;
    endfunction

    function automatic logic [TIME_W-1:0] measure_section(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - mark_time;
        prof_sum[cur_section] = prof_sum[cur_section] + elapsed;
        if (prof_min[cur_section] == '0 || elapsed < prof_min[cur_section])
            prof_min[cur_section] = elapsed;
        if (elapsed > prof_max[cur_section])
            prof_max[cur_section] = elapsed;
        return elapsed;
    endfunction

    function automatic t_profile_report predict_report(logic [KIND_W-1:0] kind,
                                                       logic [TIME_W-1:0] now);
        t_profile_report rep;
        logic [TIME_W-1:0] elapsed;
        elapsed = '0;
        case (kind)
            KIND_INIT: begin
                used_sections = 0;
                clear_profile();
            end
            KIND_CLEAR: begin
                clear_profile();
            end
            KIND_START: begin
                start_count = start_count + 1'b1;
                cur_section = 0;
                if (used_sections < 1)
                    used_sections++;
                mark_time = now;
            end
            KIND_NEXT: begin
                elapsed = measure_section(now);
                if (cur_section < DEFAULT_SECTIONS - 1)
                    cur_section++;
                if (used_sections < cur_section + 1)
                    used_sections++;
                mark_time = now;
            end
            KIND_STOP: begin
                elapsed = measure_section(now);
            end
            default: begin
            end
        endcase
        rep.section_index  = INDEX_W'(cur_section);
        rep.elapsed_cycles = elapsed;
        rep.section_min    = prof_min[cur_section];
        rep.section_max    = prof_max[cur_section];
        rep.section_sum    = prof_sum[cur_section];
        rep.start_total    = start_count;
        rep.sections_used  = USED_W'(used_sections);
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && req_if.valid && req_if.ready)
            expected_reports.push_back(predict_report(req_if.kind, req_if.cycle_time));
    end

    always @(posedge clk) begin : check_rsp
        t_profile_report want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected response: section_index %0d", rsp_if.section_index);
                fail_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("section_index", want.section_index, rsp_if.section_index);
                check_field("elapsed_cycles", want.elapsed_cycles, rsp_if.elapsed_cycles);
                check_field("section_min", want.section_min, rsp_if.section_min);
                check_field("section_max", want.section_max, rsp_if.section_max);
                check_field("section_sum", want.section_sum, rsp_if.section_sum);
                check_field("start_total", want.start_total, rsp_if.start_total);
                check_field("sections_used", want.sections_used, rsp_if.sections_used);
            end
        end
    end

    always @(posedge clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.cycle_time <= stamp;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] next_delta();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return '0;
        else if (pick < 60)
            return TIME_W'($urandom_range(1, 64));
        else if (pick < 90)
            return TIME_W'($urandom_range(1, 65535));
        else
            return TIME_W'($urandom);
    endfunction

    task automatic send_at_delta(input logic [KIND_W-1:0] kind);
        clock_now = clock_now + next_delta();
        send_event(kind, clock_now);
    endtask

    // start, a run of sections, stop; sometimes a stray stop in the middle or a second stop at the end
    task automatic run_profiled_task();
        int unsigned n_next;
        n_next = $urandom_range(DEFAULT_SECTIONS + 1);
        send_at_delta(KIND_START);
        for (int i = 0; i < n_next; i++) begin
            if ($urandom_range(7) == 0)
                send_at_delta(KIND_STOP);
            send_at_delta(KIND_NEXT);
        end
        send_at_delta(KIND_STOP);
        if ($urandom_range(3) == 0)
            send_at_delta(KIND_STOP);
    endtask

    task automatic run_random_mix(input int count);
        int unsigned pick;
        int          target;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                run_profiled_task();
            end else if (pick < 88) begin
                send_event(KIND_W'($urandom_range(2**KIND_W - 1)), TIME_W'($urandom));
            end else if (pick < 92) begin
                send_at_delta(KIND_NEXT);
            end else if (pick < 95) begin
                send_event($urandom_range(1) ? KIND_INIT : KIND_CLEAR, TIME_W'($urandom));
            end else begin
                hold_until_drained();
            end
        end
    endtask

    task automatic test_directed_cases();
        send_event(KIND_INIT, '0);
        send_event(KIND_START, '0);
        send_event(KIND_NEXT, '0);
        send_event(KIND_STOP, 32'd5);
        send_event(KIND_NEXT, '1);
        send_event(KIND_STOP, 32'h0000_0010);
        for (int i = 1; i <= 7; i++)
            send_event(KIND_NEXT, TIME_W'(i));
        for (int k = int'(KIND_STOP) + 1; k < 2**KIND_W; k++)
            send_event(KIND_W'(k), '1);
        send_event(KIND_CLEAR, 32'h8000_0000);
        send_event(KIND_NEXT, 32'd3);
        send_event(KIND_INIT, 32'h5555_5555);
        send_event(KIND_NEXT, 32'hAAAA_AAAA);
        send_event(KIND_NEXT, 32'hFFFF_FFFE);
        send_event(KIND_STOP, '1);
        hold_until_drained();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_sparse_requests();
        send_idle_pct  = 82;
        recv_stall_pct = 0;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_response_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        run_random_mix(PHASE_ITEMS);
    endtask

    task automatic test_mixed_throttle();
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        run_random_mix(PHASE_ITEMS);
    endtask

    initial begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_INIT;
        req_if.cycle_time = '0;
        rsp_if.ready      = 1'b0;
        fail_count        = 0;
        items_sent        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        clock_now         = '0;
        used_sections     = 0;
        clear_profile();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_back_to_back();
        test_sparse_requests();
        test_response_backpressure();
        test_mixed_throttle();

        hold_until_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
